>>> rtl/frr_pkg.sv
// ============================================================================
// frr_pkg
// Types, codes and register constants shared by the fragment reassembly
// receiver and its channel interfaces.
// ============================================================================
`timescale 1ns / 1ps

package frr_pkg;

    // Item actions
    localparam logic [1:0] ACT_FRAGMENT = 2'd0;
    localparam logic [1:0] ACT_READ     = 2'd1;
    localparam logic [1:0] ACT_CLEAR    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_TOO_LARGE = 2'd3;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MAX_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_FRAGMENT_SIZE  = 2'd1;
    localparam logic [1:0] REG_MAX_FRAG_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [16:0] RST_MAX_BLOCK_SIZE = 17'd65536;
    localparam logic [10:0] RST_FRAGMENT_SIZE  = 11'd1024;
    localparam logic [10:0] RST_MAX_FRAG_COUNT = 11'd64;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // Input item
    typedef struct packed {
        logic [1:0]  action;
        logic [16:0] block_size;
        logic [15:0] fragment_count;
        logic [15:0] fragment_id;
        logic [10:0] fragment_bytes;
        logic [9:0]  byte_offset;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] read_address;
    } t_frr_in;

    // Result item
    typedef struct packed {
        logic [1:0]  status;
        logic        ack_valid;
        logic [9:0]  ack_fragment_id;
        logic        complete;
        logic [16:0] assembled_size;
        logic [10:0] received_total;
        logic [7:0]  read_data;
    } t_frr_out;

endpackage

>>> rtl/frr_in_if.sv
// ============================================================================
// frr_in_if
// Input item channel: valid/ready handshake with a fragment item payload.
// ============================================================================
`timescale 1ns / 1ps

interface frr_in_if;
    logic             valid;
    logic             ready;
    frr_pkg::t_frr_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/frr_out_if.sv
// ============================================================================
// frr_out_if
// Result item channel: valid/ready handshake with a result item payload.
// ============================================================================
`timescale 1ns / 1ps

interface frr_out_if;
    logic              valid;
    logic              ready;
    frr_pkg::t_frr_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/fragment_reassembly_receiver_top.sv
// ============================================================================
// fragment_reassembly_receiver_top
// Rebuilds one data block from byte-wide fragment items into a block store,
// tracking received fragments in a bitmap memory.
// Flow: the item is captured with its bitmap/store reads on accept, then the
//   execute state writes back and registers the result; execute waits while
//   the previous result still waits in the output register. A new item is
//   taken only after write back; a clear item adds the bitmap clearing pass.
// Reset: synchronous active low; clears control and config registers, then
//   sweeps all MAX_FRAGMENTS bitmap entries before the first item.
// ============================================================================
`timescale 1ns / 1ps

module fragment_reassembly_receiver_top #(
    parameter int MAX_BLOCK_BYTES = 65536,
    parameter int MAX_FRAGMENTS   = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    frr_in_if.sink       i_frag,
    frr_out_if.source    o_res,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = $clog2(MAX_BLOCK_BYTES);
    localparam int MW = $clog2(MAX_FRAGMENTS);
    localparam logic [27:0]   MaxBlk  = 28'(MAX_BLOCK_BYTES);
    localparam logic [MW-1:0] LastIdx = MW'(MAX_FRAGMENTS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    frr_pkg::t_state   r_state, n_state;
    logic [MW-1:0]     r_clr_idx, n_clr_idx;
    frr_pkg::t_frr_in  r_in;
    logic [26:0]       r_start;
    logic              r_map_rd;
    logic [7:0]        r_store_rd;
    logic [16:0]       r_lat_size, n_lat_size;
    logic [10:0]       r_lat_cnt, n_lat_cnt;
    logic [10:0]       r_rcv_cnt, n_rcv_cnt;
    logic              r_too_large, n_too_large;
    frr_pkg::t_frr_out r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [16:0]       r_max_blk;
    logic [10:0]       r_frag_size;
    logic [10:0]       r_max_frag;

    // Memories
    logic [7:0]        mem_store [MAX_BLOCK_BYTES];
    logic              mem_map   [MAX_FRAGMENTS];

    logic              store_we;
    logic [AW-1:0]     store_wa;
    logic              map_we;
    logic [MW-1:0]     map_wa;
    logic              map_wd;

    logic              accept;
    logic              cfg_wr;

    // Fragment check results
    logic [16:0]       lim_size;
    logic [10:0]       lim_count;
    logic [16:0]       lsize_eff;
    logic [10:0]       lcount_eff;
    logic [27:0]       finish;
    logic [27:0]       wr_sum;
    logic [1:0]        f_status;
    logic              f_ack;
    logic              f_store;
    logic              f_mark;
    logic [16:0]       f_nsize;
    logic [10:0]       f_ncnt;
    logic              f_flag;
    logic              cur_complete;
    logic [7:0]        rdata;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_blk   <= frr_pkg::RST_MAX_BLOCK_SIZE;
            r_frag_size <= frr_pkg::RST_FRAGMENT_SIZE;
            r_max_frag  <= frr_pkg::RST_MAX_FRAG_COUNT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                frr_pkg::REG_MAX_BLOCK_SIZE: r_max_blk   <= pwdata[16:0];
                frr_pkg::REG_FRAGMENT_SIZE:  r_frag_size <= pwdata[10:0];
                frr_pkg::REG_MAX_FRAG_COUNT: r_max_frag  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            frr_pkg::REG_MAX_BLOCK_SIZE: prdata = {15'd0, r_max_blk};
            frr_pkg::REG_FRAGMENT_SIZE:  prdata = {21'd0, r_frag_size};
            frr_pkg::REG_MAX_FRAG_COUNT: prdata = {21'd0, r_max_frag};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign i_frag.ready = (r_state == frr_pkg::S_IDLE);
    assign accept       = i_frag.valid && i_frag.ready;
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    // ------------------------------------------------------------------
    // Memories: read on accept, write back during execute or clear sweep
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            mem_store[store_wa] <= r_in.data_byte;
        end
        if (accept) begin
            r_store_rd <= mem_store[AW'(i_frag.data.read_address)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[map_wa] <= map_wd;
        end
        if (accept) begin
            r_map_rd <= mem_map[MW'(i_frag.data.fragment_id)];
        end
    end

    // Item capture and fragment start offset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in    <= i_frag.data;
            r_start <= {11'd0, i_frag.data.fragment_id} * {16'd0, r_frag_size};
        end
    end

    // ------------------------------------------------------------------
    // Fragment checks on the captured item
    // ------------------------------------------------------------------
    always_comb begin
        lim_size   = ({15'd0, r_max_blk} < 32'(MAX_BLOCK_BYTES)) ?
                     r_max_blk : 17'(MAX_BLOCK_BYTES);
        lim_count  = ({21'd0, r_max_frag} < 32'(MAX_FRAGMENTS)) ?
                     r_max_frag : 11'(MAX_FRAGMENTS);
        lsize_eff  = (r_lat_size == 17'd0) ? r_in.block_size : r_lat_size;
        lcount_eff = (r_lat_cnt == 11'd0) ? r_in.fragment_count[10:0] : r_lat_cnt;
        finish     = {1'b0, r_start} + {17'd0, r_in.fragment_bytes};
        wr_sum     = {1'b0, r_start} + {18'd0, r_in.byte_offset};

        f_status = frr_pkg::ST_OK;
        f_ack    = 1'b0;
        f_store  = 1'b0;
        f_mark   = 1'b0;
        f_nsize  = r_lat_size;
        f_ncnt   = r_lat_cnt;
        f_flag   = r_too_large;

        if (r_in.block_size > lim_size) begin
            f_flag   = 1'b1;
            f_status = frr_pkg::ST_TOO_LARGE;
        end else if (r_too_large) begin
            f_status = frr_pkg::ST_TOO_LARGE;
        end else begin
            // size latches even if later checks reject the byte
            f_nsize = lsize_eff;
            if (lsize_eff != r_in.block_size) begin
                f_status = frr_pkg::ST_IGNORED;
            end else if ({5'd0, lim_count} < r_in.fragment_count) begin
                f_status = frr_pkg::ST_IGNORED;
            end else begin
                f_ncnt = lcount_eff;
                if ({5'd0, lcount_eff} != r_in.fragment_count) begin
                    f_status = frr_pkg::ST_IGNORED;
                end else if (r_in.fragment_id >= {5'd0, lcount_eff}) begin
                    f_status = frr_pkg::ST_IGNORED;
                end else if (finish > {11'd0, lsize_eff}) begin
                    f_status = frr_pkg::ST_IGNORED;
                end else if (r_map_rd) begin
                    f_status = frr_pkg::ST_DUPLICATE;
                    f_ack    = r_in.last_byte;
                end else begin
                    f_store = ({1'b0, r_in.byte_offset} < r_in.fragment_bytes) &&
                              (wr_sum < MaxBlk);
                    f_mark  = r_in.last_byte;
                    f_ack   = r_in.last_byte;
                end
            end
        end

        cur_complete = (r_lat_size != 17'd0) && (r_rcv_cnt == r_lat_cnt);
        rdata = (cur_complete && ({1'b0, r_in.read_address} < r_lat_size) &&
                 ({12'd0, r_in.read_address} < MaxBlk)) ? r_store_rd : 8'd0;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state, write back and result
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_lat_size  = r_lat_size;
        n_lat_cnt   = r_lat_cnt;
        n_rcv_cnt   = r_rcv_cnt;
        n_too_large = r_too_large;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        store_we    = 1'b0;
        store_wa    = wr_sum[AW-1:0];
        map_we      = 1'b0;
        map_wa      = r_in.fragment_id[MW-1:0];
        map_wd      = 1'b1;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            frr_pkg::S_CLEAR: begin
                map_we    = 1'b1;
                map_wa    = r_clr_idx;
                map_wd    = 1'b0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LastIdx) begin
                    n_state = frr_pkg::S_IDLE;
                end
            end
            frr_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = frr_pkg::S_EXEC;
                end
            end
            frr_pkg::S_EXEC: begin
                // finish only when the result register can take the item
                if (!r_out_valid || o_res.ready) begin
                    n_out.status          = frr_pkg::ST_OK;
                    n_out.ack_valid       = 1'b0;
                    n_out.ack_fragment_id = 10'd0;
                    n_out.read_data       = 8'd0;
                    n_state               = frr_pkg::S_IDLE;
                    case (r_in.action)
                        frr_pkg::ACT_FRAGMENT: begin
                            n_too_large = f_flag;
                            n_lat_size  = f_nsize;
                            n_lat_cnt   = f_ncnt;
                            store_we    = f_store;
                            map_we      = f_mark;
                            if (f_mark) begin
                                n_rcv_cnt = r_rcv_cnt + 11'd1;
                            end
                            n_out.status          = f_status;
                            n_out.ack_valid       = f_ack;
                            n_out.ack_fragment_id = f_ack ? r_in.fragment_id[9:0] : 10'd0;
                        end
                        frr_pkg::ACT_READ: begin
                            n_out.read_data = rdata;
                        end
                        frr_pkg::ACT_CLEAR: begin
                            n_too_large = 1'b0;
                            n_lat_size  = 17'd0;
                            n_lat_cnt   = 11'd0;
                            n_rcv_cnt   = 11'd0;
                            n_clr_idx   = '0;
                            n_state     = frr_pkg::S_CLEAR;
                        end
                        default: ;
                    endcase
                    n_out.complete       = (n_lat_size != 17'd0) && (n_rcv_cnt == n_lat_cnt);
                    n_out.assembled_size = n_lat_size;
                    n_out.received_total = n_rcv_cnt;
                    n_out_valid          = 1'b1;
                end
            end
            default: begin
                n_state = frr_pkg::S_CLEAR;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frr_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_lat_size  <= 17'd0;
            r_lat_cnt   <= 11'd0;
            r_rcv_cnt   <= 11'd0;
            r_too_large <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_lat_size  <= n_lat_size;
            r_lat_cnt   <= n_lat_cnt;
            r_rcv_cnt   <= n_rcv_cnt;
            r_too_large <= n_too_large;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a new result only comes out of the execute step
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == frr_pkg::S_EXEC))
        else $error("result raised outside execute");

    // distinct fragments never outnumber the latched count
    a_rcv_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcv_cnt <= r_lat_cnt)
        else $error("received count above latched count");

    // no item is taken during the bitmap clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frr_pkg::S_CLEAR) |-> !i_frag.ready)
        else $error("item accepted during clear sweep");

    // acks come only with accepted or duplicate fragments
    a_ack_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ack_valid) |->
            (r_out.status == frr_pkg::ST_OK || r_out.status == frr_pkg::ST_DUPLICATE))
        else $error("ack with rejecting status");
`endif

endmodule
